// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/apa_pkg.sv
// ----------------------------------------------------------------------------
// apa_pkg
// Shared widths, constants and types of the pedestal accumulator.
// ----------------------------------------------------------------------------
package apa_pkg;

  localparam int CH_W      = 5;
  localparam int ADC_W     = 20;
  localparam int CNT_W     = 16;
  localparam int SUM_W     = 36;
  localparam int CUT_W     = 21;
  localparam int PED_W     = 24;
  localparam int MINP_W    = 16;
  localparam int FRAC_W    = 4;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam int NUM_CHANNELS_DEF = 32;
  localparam int MAX_REPORT       = 32;

  // bit-serial divider: (sum << 4) / count, one quotient bit per cycle
  localparam int DIV_DVD_W = SUM_W + FRAC_W;
  localparam int DIV_STEPS = DIV_DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [CNT_W-1:0]  CNT_MAX      = '1;
  localparam logic [CUT_W-1:0]  CUT_OFFSET   = 21'd100;
  localparam logic [PED_W-1:0]  THR_OFFSET   = 24'd240;
  localparam logic [MINP_W-1:0] MIN_PEDS_RST = 16'd500;
  localparam logic [ADC_W-1:0]  INIT_CUT_RST = 20'hFFFFF;

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic [CUT_W-1:0] cut;
    logic [PED_W-1:0] mean;
  } entry_t;

  typedef struct packed {
    logic [MINP_W-1:0] min_peds;
    logic [CNT_W-1:0]  trigger;
    logic [ADC_W-1:0]  initial_cut;
    logic              cut_reload;
  } cfg_regs_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: sv/apa_ram.sv
// ----------------------------------------------------------------------------
// apa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module apa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/apa_cfg.sv
// ----------------------------------------------------------------------------
// apa_cfg
// APB register file: min_peds (with its precomputed fifth) and initial_cut.
// ----------------------------------------------------------------------------
module apa_cfg
  import apa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_regs_t         cfg
);

  localparam logic REG_MIN_PEDS    = 1'b0;
  localparam logic REG_INITIAL_CUT = 1'b1;

  // x / 5 for 16-bit x as (x * 0xCCCD) >> 18
  localparam logic [16:0]      TRIG_RECIP = 17'd52429;
  localparam int               TRIG_SHIFT = 18;
  localparam logic [CNT_W-1:0] TRIG_RST   = CNT_W'(MIN_PEDS_RST / 5);

  logic [MINP_W-1:0] min_peds_r, min_peds_nxt;
  logic [ADC_W-1:0]  init_cut_r, init_cut_nxt;
  logic [CNT_W-1:0]  trig_r, trig_nxt;
  logic [32:0]       trig_prod;
  logic              wr_en;
  logic              reg_sel;

  assign wr_en     = psel & penable & pwrite & pready;
  assign reg_sel   = paddr[2];
  assign pready    = 1'b1;
  assign trig_prod = {17'b0, pwdata[MINP_W-1:0]} * {16'b0, TRIG_RECIP};

  always_comb begin
    min_peds_nxt = min_peds_r;
    init_cut_nxt = init_cut_r;
    trig_nxt     = trig_r;
    if (wr_en) begin
      case (reg_sel)
        REG_MIN_PEDS: begin
          min_peds_nxt = pwdata[MINP_W-1:0];
          trig_nxt     = trig_prod[TRIG_SHIFT +: CNT_W];
        end
        REG_INITIAL_CUT: begin
          init_cut_nxt = pwdata[ADC_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_peds_r <= MIN_PEDS_RST;
      init_cut_r <= INIT_CUT_RST;
      trig_r     <= TRIG_RST;
    end else begin
      min_peds_r <= min_peds_nxt;
      init_cut_r <= init_cut_nxt;
      trig_r     <= trig_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MIN_PEDS:    prdata = {{(CFG_DW-MINP_W){1'b0}}, min_peds_r};
      REG_INITIAL_CUT: prdata = {{(CFG_DW-ADC_W){1'b0}}, init_cut_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.min_peds    = min_peds_r;
  assign cfg.trigger     = trig_r;
  assign cfg.initial_cut = init_cut_r;
  // every channel's cut falls back to initial_cut on this write
  assign cfg.cut_reload  = wr_en && (reg_sel == REG_INITIAL_CUT);

endmodule

// File: sv/apa_div.sv
// ----------------------------------------------------------------------------
// apa_div
// Restoring bit-serial divider, one quotient bit per cycle, low bits kept.
// ----------------------------------------------------------------------------
module apa_div
  import apa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [CNT_W-1:0]     divisor,
  output div_stat_t            stat,
  output logic [PED_W-1:0]     quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic [DIV_DVD_W-1:0] dvd_r;
  logic [CNT_W-1:0]     dsr_r;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [PED_W-1:0]     quo_r;
  logic [CNT_W:0]       trial;
  logic                 qbit;

  // remainder stays below the divisor, so one extra bit covers the trial
  assign trial   = {rem_r, dvd_r[DIV_DVD_W-1]} - {1'b0, dsr_r};
  assign qbit    = ~trial[CNT_W];
  assign rem_nxt = qbit ? trial[CNT_W-1:0] : {rem_r[CNT_W-2:0], dvd_r[DIV_DVD_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[PED_W-2:0], qbit};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// File: sv/adc_pedestal_accumulator_core.sv
// ----------------------------------------------------------------------------
// adc_pedestal_accumulator_core
// Per-channel pedestal accumulator with adaptive cut and pedestal report.
// ----------------------------------------------------------------------------
//  port group   dir   content
//  in_*         in    tuser = kind; tdata = channel, adc_value
//  out_*        out   tdata = channel, pedestal, threshold, mean;
//                     tuser = mean_updated; tlast = last channel
//  cfg_*        apb   0x0 min_peds, 0x4 initial_cut
//
//  a sample reads its channel entry and writes it back; when it hits min_peds/5
//  the new cut needs the 40-step bit-serial divider before the write
//  a compute request runs the same divider for each reported channel in turn;
//  results wait in an output register
//  reset: synchronous; valid bits stand in for the cleared channel memory
//  an output stall holds the channel walk before its next result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adc_pedestal_accumulator_core
  import apa_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // [4:0] channel, [24:5] adc_value
  input  logic              in_tuser,   // [0] kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [79:0]       out_tdata,  // [4:0] out_channel, [28:5] pedestal,
                                        // [52:29] threshold, [76:53] pedestal_mean
  output logic              out_tuser,  // [0] mean_updated
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CH_AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int REPORT_N = (NUM_CHANNELS < MAX_REPORT) ? NUM_CHANNELS : MAX_REPORT;
  localparam logic [CH_AW-1:0] LAST_IDX = CH_AW'(REPORT_N - 1);
  localparam int ENT_W    = $bits(entry_t);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SREAD = 6'b000010,
    S_SDIV  = 6'b000100,
    S_CREAD = 6'b001000,
    S_CDIV  = 6'b010000,
    S_COUT  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CH_AW-1:0]  addr_r, addr_nxt;
  logic [ADC_W-1:0]  adc_r, adc_nxt;
  entry_t            ent_r, ent_nxt;
  logic [PED_W-1:0]  ped_r, ped_nxt;
  logic [NUM_CHANNELS-1:0] acc_vld_r, cut_vld_r;

  cfg_regs_t         cfg;
  div_stat_t         div_stat;
  logic              div_start;
  logic [DIV_DVD_W-1:0] div_dvd;
  logic [CNT_W-1:0]  div_dsr;
  logic [PED_W-1:0]  div_q;

  logic              ram_we;
  entry_t            ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;
  entry_t            rd_raw, rd_ent, upd_ent;

  logic [CH_W-1:0]   in_ch;
  logic [ADC_W-1:0]  in_adc;
  logic              in_kind;
  logic              ch_ok;
  logic              take_ok;
  logic              mean_upd;
  logic [PED_W:0]    thr_sum;
  logic [PED_W-1:0]  thr;
  logic              out_load;

  logic              out_tvalid_r;
  logic [79:0]       out_tdata_r;
  logic              out_tuser_r, out_tlast_r;

  assign in_ch   = in_tdata[CH_W-1:0];
  assign in_adc  = in_tdata[CH_W +: ADC_W];
  assign in_kind = in_tuser;
  assign ch_ok   = 32'(in_ch) < NUM_CHANNELS;
  assign in_tready = (state_r == S_IDLE);

  apa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  apa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .stat     (div_stat),
    .quotient (div_q)
  );

  apa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_CHANNELS),
    .AW    (CH_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .raddr (addr_nxt),
    .rdata (ram_rdata)
  );

  // unwritten entries read as the reset state
  always_comb begin
    rd_raw = entry_t'(ram_rdata);
    rd_ent = rd_raw;
    if (!acc_vld_r[addr_r]) begin
      rd_ent.count = '0;
      rd_ent.sum   = '0;
      rd_ent.mean  = '0;
    end
    if (!cut_vld_r[addr_r]) begin
      rd_ent.cut = {1'b0, cfg.initial_cut};
    end
  end

  always_comb begin
    upd_ent       = rd_ent;
    upd_ent.sum   = rd_ent.sum + SUM_W'(adc_r);
    upd_ent.count = rd_ent.count + 1'b1;
  end

  assign take_ok  = ({1'b0, adc_r} <= rd_ent.cut) && (rd_ent.count != CNT_MAX);
  assign mean_upd = (cfg.min_peds != '0) && (ent_r.count > cfg.min_peds);
  assign thr_sum  = {1'b0, ped_r} + {1'b0, THR_OFFSET};
  assign thr      = thr_sum[PED_W] ? '1 : thr_sum[PED_W-1:0];

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    adc_nxt   = adc_r;
    ent_nxt   = ent_r;
    ped_nxt   = ped_r;
    ram_we    = 1'b0;
    ram_wdata = ent_r;
    div_start = 1'b0;
    div_dvd   = {rd_ent.sum, {FRAC_W{1'b0}}};
    div_dsr   = (rd_ent.count == '0) ? CNT_W'(1) : rd_ent.count;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          adc_nxt = in_adc;
          if (in_kind == KIND_COMPUTE) begin
            addr_nxt  = '0;
            state_nxt = S_CREAD;
          end else if (ch_ok) begin
            addr_nxt  = CH_AW'(in_ch);
            state_nxt = S_SREAD;
          end
        end
      end
      S_SREAD: begin
        state_nxt = S_IDLE;
        if (take_ok) begin
          if (upd_ent.count == cfg.trigger) begin
            ent_nxt   = upd_ent;
            div_start = 1'b1;
            div_dvd   = {upd_ent.sum, {FRAC_W{1'b0}}};
            div_dsr   = upd_ent.count;
            state_nxt = S_SDIV;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = upd_ent;
          end
        end
      end
      S_SDIV: begin
        if (div_stat.done) begin
          // floor(16s/c) >> 4 is the integer mean
          ram_wdata.cut = CUT_OFFSET + {1'b0, div_q[PED_W-1:FRAC_W]};
          ram_we        = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_CREAD: begin
        ent_nxt   = rd_ent;
        div_start = 1'b1;
        state_nxt = S_CDIV;
      end
      S_CDIV: begin
        if (div_stat.done) begin
          ped_nxt   = div_q;
          state_nxt = S_COUT;
        end
      end
      S_COUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load = 1'b1;
          if (mean_upd) begin
            ram_we         = 1'b1;
            ram_wdata.mean = ped_r;
          end
          if (addr_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end else begin
            addr_nxt  = addr_r + 1'b1;
            state_nxt = S_CREAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      acc_vld_r    <= '0;
      cut_vld_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        acc_vld_r[addr_r] <= 1'b1;
      end
      if (cfg.cut_reload) begin
        cut_vld_r <= '0;
      end else if (ram_we) begin
        cut_vld_r[addr_r] <= 1'b1;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    adc_r  <= adc_nxt;
    ent_r  <= ent_nxt;
    ped_r  <= ped_nxt;
    if (out_load) begin
      out_tdata_r <= {3'b0, (mean_upd ? ped_r : ent_r.mean), thr, ped_r, CH_W'(addr_r)};
      out_tuser_r <= mean_upd;
      out_tlast_r <= (addr_r == LAST_IDX);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `ASSERT_IMPLY(a_div_start_free, div_start, !div_stat.busy, "divider restarted while busy")
  `ASSERT_IMPLY(a_ram_we_busy, ram_we, !in_tready, "channel memory written while idle")
  `ASSERT_IMPLY(a_walk_range, state_r == S_CREAD, addr_r <= LAST_IDX, "walk past last channel")
  `ASSERT_NEXT(a_walk_ends, out_load && (addr_r == LAST_IDX), in_tready, "walk ran past last")

endmodule

// File: test/adc_pedestal_accumulator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_pedestal_accumulator_checker
// Watches the request, report and register ports of the pedestal accumulator,
// keeps its own copy of the per-channel sums, counts, cuts and stored means,
// and compares every channel report field by field with the predicted one.
// ----------------------------------------------------------------------------
module adc_pedestal_accumulator_checker
  import apa_pkg::*;
#(
  parameter int                NUM_CHANNELS  = NUM_CHANNELS_DEF,
  parameter logic [CFG_AW-1:0] MIN_PEDS_ADDR = CFG_AW'(0),
  parameter logic [CFG_AW-1:0] INIT_CUT_ADDR = CFG_AW'(4)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [31:0]       in_tdata,   // [4:0] channel, [24:5] adc_value
  input  logic              in_tuser,   // [0] kind
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [79:0]       out_tdata,  // [4:0] channel, [28:5] pedestal,
                                        // [52:29] threshold, [76:53] pedestal_mean
  input  logic              out_tuser,  // [0] mean_updated
  input  logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                mismatch_count,
  output int                reports_pending,
  output int                reports_checked
);

  localparam int REPORTS     = (NUM_CHANNELS < MAX_REPORT) ? NUM_CHANNELS : MAX_REPORT;
  localparam int TRIGGER_DIV = 5;
  localparam int SCALED_W    = SUM_W + FRAC_W;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [PED_W-1:0] pedestal;
    logic [PED_W-1:0] threshold;
    logic [PED_W-1:0] mean;
    logic             updated;
    logic             last;
  } ped_report_t;

  logic [MINP_W-1:0] min_peds_q;
  logic [ADC_W-1:0]  init_cut_q;
  logic [CNT_W-1:0]  count_m [NUM_CHANNELS];
  logic [SUM_W-1:0]  sum_m   [NUM_CHANNELS];
  logic [CUT_W-1:0]  cut_m   [NUM_CHANNELS];
  logic [PED_W-1:0]  mean_m  [NUM_CHANNELS];

  ped_report_t expected_reports [$];
  ped_report_t got_rpt;
  ped_report_t exp_rpt;

  function void reload_cuts();
    for (int i = 0; i < NUM_CHANNELS; i++) cut_m[i] = CUT_W'(init_cut_q);
  endfunction

  function void accumulate_sample(input logic [CH_W-1:0] ch, input logic [ADC_W-1:0] adc);
    logic [CNT_W-1:0] trig;
    if (ch >= NUM_CHANNELS) return;
    if ({1'b0, adc} > cut_m[ch] || count_m[ch] == CNT_MAX) return;
    sum_m[ch]   = sum_m[ch] + SUM_W'(adc);
    count_m[ch] = count_m[ch] + 1'b1;
    // a zero trigger never matches since the count is at least one here
    trig = CNT_W'(min_peds_q / TRIGGER_DIV);
    if (count_m[ch] == trig) cut_m[ch] = CUT_OFFSET + CUT_W'(sum_m[ch] / count_m[ch]);
  endfunction

  function void predict_reports();
    logic [CNT_W-1:0]    divisor;
    logic [SCALED_W-1:0] scaled;
    logic [PED_W:0]      thr_wide;
    ped_report_t         r;
    for (int i = 0; i < REPORTS; i++) begin
      divisor = (count_m[i] == '0) ? CNT_W'(1) : count_m[i];
      scaled  = {sum_m[i], {FRAC_W{1'b0}}} / divisor;
      r.pedestal = (|scaled[SCALED_W-1:PED_W]) ? '1 : scaled[PED_W-1:0];
      thr_wide = {1'b0, r.pedestal} + {1'b0, THR_OFFSET};
      r.threshold = thr_wide[PED_W] ? '1 : thr_wide[PED_W-1:0];
      r.updated = (min_peds_q != '0) && (count_m[i] > min_peds_q);
      if (r.updated) mean_m[i] = r.pedestal;
      r.channel = CH_W'(i);
      r.mean    = mean_m[i];
      r.last    = (i == REPORTS - 1);
      expected_reports = {expected_reports, r};
    end
  endfunction

  function void check_field(input string name, input logic [CH_W-1:0] ch,
                            input logic [PED_W-1:0] exp_v, input logic [PED_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch on channel %0d: expected %0d, actual %0d",
               $time, name, ch, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      min_peds_q = MIN_PEDS_RST;
      init_cut_q = INIT_CUT_RST;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        count_m[i] = '0;
        sum_m[i]   = '0;
        mean_m[i]  = '0;
      end
      reload_cuts();
      expected_reports.delete();
      reports_pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_rpt.channel   = out_tdata[CH_W-1:0];
        got_rpt.pedestal  = out_tdata[CH_W +: PED_W];
        got_rpt.threshold = out_tdata[CH_W+PED_W +: PED_W];
        got_rpt.mean      = out_tdata[CH_W+2*PED_W +: PED_W];
        got_rpt.updated   = out_tuser;
        got_rpt.last      = out_tlast;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report: expected none, actual channel %0d pedestal %0d",
                   $time, got_rpt.channel, got_rpt.pedestal);
          mismatch_count++;
        end else begin
          exp_rpt = expected_reports.pop_front();
          check_field("channel", exp_rpt.channel, PED_W'(exp_rpt.channel),
                      PED_W'(got_rpt.channel));
          check_field("pedestal", exp_rpt.channel, exp_rpt.pedestal, got_rpt.pedestal);
          check_field("threshold", exp_rpt.channel, exp_rpt.threshold, got_rpt.threshold);
          check_field("pedestal_mean", exp_rpt.channel, exp_rpt.mean, got_rpt.mean);
          check_field("mean_updated", exp_rpt.channel, PED_W'(exp_rpt.updated),
                      PED_W'(got_rpt.updated));
          check_field("last", exp_rpt.channel, PED_W'(exp_rpt.last), PED_W'(got_rpt.last));
          reports_checked++;
        end
      end

      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_COMPUTE) begin
          predict_reports();
        end else begin
          accumulate_sample(in_tdata[CH_W-1:0], in_tdata[CH_W +: ADC_W]);
        end
      end

      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          MIN_PEDS_ADDR: begin
            min_peds_q = cfg_pwdata[MINP_W-1:0];
          end
          INIT_CUT_ADDR: begin
            init_cut_q = cfg_pwdata[ADC_W-1:0];
            reload_cuts();
          end
          default: begin
          end
        endcase
      end

      reports_pending <= expected_reports.size();
    end
  end

endmodule

// File: test/tb_adc_pedestal_accumulator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adc_pedestal_accumulator_core
// Drives sample and compute requests and register writes into the pedestal
// accumulator; a checker beside it predicts and compares every report.
// ----------------------------------------------------------------------------
module tb_adc_pedestal_accumulator_core;
  import apa_pkg::*;

  localparam int                CLK_PERIOD        = 8;
  localparam int                RESET_CYCLES      = 3;
  localparam logic [CFG_AW-1:0] MIN_PEDS_ADDR     = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] INIT_CUT_ADDR     = CFG_AW'(4);
  localparam int                RANDOM_SETTINGS   = 6;
  localparam int                ITEMS_PER_SETTING = 56;
  localparam int                RANDOM_ITEMS      = RANDOM_SETTINGS * ITEMS_PER_SETTING;
  localparam int                SETTLE_CYCLES     = 100;
  localparam int                FILL_ITEMS        = 16;
  localparam longint            LIMIT_NS          = 40_000_000;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata    = '0;
  logic              in_tuser    = 1'b0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [79:0]       out_tdata;
  logic              out_tuser;
  logic              out_tlast;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int mismatch_count;
  int reports_pending;
  int reports_checked;
  int send_idle_pct = 20;
  int recv_idle_pct = 82;
  int n_samples     = 0;
  int n_computes    = 0;
  int n_settings    = 1;

  adc_pedestal_accumulator_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  adc_pedestal_accumulator_checker #(
    .MIN_PEDS_ADDR (MIN_PEDS_ADDR),
    .INIT_CUT_ADDR (INIT_CUT_ADDR)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_pready      (cfg_pready),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending),
    .reports_checked (reports_checked)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays high after a handshake so back-to-back requests need no toggle
  task automatic send_item(input logic kind, input logic [CH_W-1:0] ch,
                           input logic [ADC_W-1:0] adc);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(32-CH_W-ADC_W){1'b0}}, adc, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == KIND_COMPUTE) n_computes++;
    else n_samples++;
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // the first edge lets the checker publish reports due from the last request
  task automatic reach_idle(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    logic [CH_W-1:0]   hot_ch [4];
    logic [CH_W-1:0]   ch_v;
    logic [CH_W-1:0]   fill_ch;
    logic [ADC_W-1:0]  adc_v;
    logic [ADC_W-1:0]  base_adc;
    logic [MINP_W-1:0] setting_mp;
    logic [ADC_W-1:0]  setting_cut;
    int                idx;
    int                pick;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: empty channels, then full-scale samples saturate the threshold
    send_item(KIND_COMPUTE, '0, '0);
    send_item(KIND_SAMPLE, 5'd31, '1);
    send_item(KIND_SAMPLE, 5'd31, '1);
    send_item(KIND_SAMPLE, 5'd0, '0);
    send_item(KIND_SAMPLE, 5'd1, 20'd1);
    send_item(KIND_SAMPLE, 5'd21, 20'hAAAAA);
    send_item(KIND_SAMPLE, 5'd10, 20'h55555);
    send_item(KIND_COMPUTE, '1, '1);

    // trigger of two: cut adapts to 100 plus mean, values right at the cut pass
    reach_idle(SETTLE_CYCLES);
    write_reg(MIN_PEDS_ADDR, CFG_DW'(16'd10));
    write_reg(INIT_CUT_ADDR, CFG_DW'(20'd512));
    n_settings++;
    send_item(KIND_SAMPLE, 5'd2, 20'd300);
    send_item(KIND_SAMPLE, 5'd2, 20'd100);
    send_item(KIND_SAMPLE, 5'd2, 20'd301);
    send_item(KIND_SAMPLE, 5'd2, 20'd300);
    send_item(KIND_SAMPLE, 5'd3, 20'd513);
    send_item(KIND_SAMPLE, 5'd3, 20'd512);
    send_item(KIND_COMPUTE, 5'd7, 20'd9);

    // zero trigger, means replaced once a count passes one
    reach_idle(SETTLE_CYCLES);
    write_reg(MIN_PEDS_ADDR, CFG_DW'(16'd1));
    n_settings++;
    send_item(KIND_SAMPLE, 5'd4, 20'd7);
    send_item(KIND_COMPUTE, '0, '0);

    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      case (p)
        0: begin setting_mp = 16'd20;  setting_cut = '1;        end
        1: begin setting_mp = '0;      setting_cut = 20'd5000;  end
        2: begin setting_mp = 16'd3;   setting_cut = 20'd2000;  end
        3: begin setting_mp = '1;      setting_cut = '0;        end
        4: begin setting_mp = 16'd40;  setting_cut = 20'h80000; end
        default: begin setting_mp = 16'd9; setting_cut = 20'd1000; end
      endcase
      reach_idle(SETTLE_CYCLES);
      write_reg(MIN_PEDS_ADDR, CFG_DW'(setting_mp));
      write_reg(INIT_CUT_ADDR, CFG_DW'(setting_cut));
      n_settings++;
      foreach (hot_ch[h]) hot_ch[h] = CH_W'($urandom_range(31));
      base_adc = (setting_cut < 200) ? '0 : ADC_W'($urandom_range(setting_cut - 200));

      for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
        idx = p * ITEMS_PER_SETTING + k;
        if (idx < RANDOM_ITEMS / 3) begin
          send_idle_pct = 20;
          recv_idle_pct = 82;
        end else if (idx < 2 * RANDOM_ITEMS / 3) begin
          send_idle_pct = 82;
          recv_idle_pct = 20;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (idx == 60 || idx == 200) reach_idle(0);

        pick = $urandom_range(99);
        if (pick < 8) begin
          send_item(KIND_COMPUTE, CH_W'($urandom_range(31)), ADC_W'($urandom));
        end else begin
          // mostly a few busy channels near a baseline so cuts adapt and means update
          ch_v = ($urandom_range(99) < 70) ? hot_ch[$urandom_range(3)]
                                           : CH_W'($urandom_range(31));
          pick = $urandom_range(99);
          if (pick < 10) adc_v = ADC_W'($urandom);
          else if (pick < 14) adc_v = '1;
          else if (pick < 18) adc_v = '0;
          else if (pick < 38) adc_v = base_adc;
          else adc_v = base_adc + ADC_W'($urandom_range(150));
          send_item(KIND_SAMPLE, ch_v, adc_v);
        end
      end
    end

    // one channel takes a back-to-back burst, min_peds just below the limit
    reach_idle(SETTLE_CYCLES);
    write_reg(MIN_PEDS_ADDR, CFG_DW'(16'd65534));
    write_reg(INIT_CUT_ADDR, CFG_DW'(INIT_CUT_RST));
    n_settings++;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_ch = CH_W'($urandom_range(31));
    repeat (FILL_ITEMS) send_item(KIND_SAMPLE, fill_ch, ADC_W'($urandom_range(15)));
    send_item(KIND_COMPUTE, '0, '0);
    reach_idle(SETTLE_CYCLES);

    $display("covered %0d samples and %0d compute requests under %0d register settings",
             n_samples, n_computes, n_settings);
    $display("checked %0d channel reports; channel %0d took a back-to-back burst",
             reports_checked, fill_ch);
    if (mismatch_count == 0) begin
      $display("adc_pedestal_accumulator_core test passed");
    end else begin
      $display("adc_pedestal_accumulator_core test failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("adc_pedestal_accumulator_core test failed");
    $finish;
  end

endmodule
